// ===== rtl/core/morus640_zero_message_keystream_assert.svh =====
// assertion macros shared by the keystream checker
// no dependencies; included by files that hold concurrent assertions
`ifndef MORUS640_ZERO_MESSAGE_KEYSTREAM_ASSERT_SVH
`define MORUS640_ZERO_MESSAGE_KEYSTREAM_ASSERT_SVH

// same-cycle implication
`define MKS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keystream assertion failed");

// next-cycle implication
`define MKS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keystream assertion failed");

`endif

// ===== rtl/core/mks_pkg.sv =====
// types, constants and rotation helpers for the morus-640 keystream block
// no dependencies
`default_nettype none

package mks_pkg;

  localparam int unsigned WORD_W    = 128;
  localparam int unsigned HALF_W    = 64;
  localparam int unsigned LANE_W    = 32;
  localparam int unsigned NUM_WORDS = 5;
  localparam int unsigned NUM_LANES = WORD_W / LANE_W;
  localparam int unsigned IDX_W     = 4;

  localparam int unsigned LANE_ROT0 = 5;
  localparam int unsigned LANE_ROT1 = 31;
  localparam int unsigned LANE_ROT2 = 7;
  localparam int unsigned LANE_ROT3 = 22;
  localparam int unsigned LANE_ROT4 = 13;

  typedef enum logic [0:0] {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t             state_t [NUM_WORDS];

  // rotate every 32-bit lane left by a constant amount
  function automatic word_t lane_rotl(word_t x, int unsigned r);
    word_t             y;
    logic [LANE_W-1:0] lane;
    for (int i = 0; i < NUM_LANES; i++) begin
      lane = x[LANE_W*i +: LANE_W];
      y[LANE_W*i +: LANE_W] = (lane << r) | (lane >> (LANE_W - r));
    end
    return y;
  endfunction

  // rotate the whole word left by a constant amount
  function automatic word_t word_rotl(word_t x, int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mks_if.sv =====
// valid/ready channels for load/step words and keystream words
// depends on mks_pkg
`default_nettype none

interface mks_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [mks_pkg::IDX_W-1:0]     word_index;
  logic [mks_pkg::HALF_W-1:0]    load_data;

  modport source (output valid, action, word_index, load_data, input ready);
  modport sink   (input valid, action, word_index, load_data, output ready);
endinterface

interface mks_out_if;
  logic                          valid;
  logic                          ready;
  logic [mks_pkg::HALF_W-1:0]    keystream_low;
  logic [mks_pkg::HALF_W-1:0]    keystream_high;

  modport source (output valid, keystream_low, keystream_high, input ready);
  modport sink   (input valid, keystream_low, keystream_high, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mks_state_update.sv =====
// keystream word and five-round zero-message state update of morus-640
// depends on mks_pkg
`default_nettype none

module mks_state_update (
  input  mks_pkg::state_t state_i,
  output mks_pkg::word_t  keystream_o,
  output mks_pkg::state_t state_o
);

  mks_pkg::word_t s0, s1, s2, s3, s4;

  assign keystream_o = state_i[0] ^ mks_pkg::word_rotl(state_i[1], 96)
                     ^ (state_i[2] & state_i[3]);

  always_comb begin
    s0 = state_i[0];
    s1 = state_i[1];
    s2 = state_i[2];
    s3 = state_i[3];
    s4 = state_i[4];

    s0 = mks_pkg::lane_rotl(s0 ^ s3 ^ (s1 & s2), mks_pkg::LANE_ROT0);
    s3 = mks_pkg::word_rotl(s3, 32);

    s1 = mks_pkg::lane_rotl(s1 ^ s4 ^ (s2 & s3), mks_pkg::LANE_ROT1);
    s4 = mks_pkg::word_rotl(s4, 64);

    s2 = mks_pkg::lane_rotl(s2 ^ s0 ^ (s3 & s4), mks_pkg::LANE_ROT2);
    s0 = mks_pkg::word_rotl(s0, 96);

    s3 = mks_pkg::lane_rotl(s3 ^ s1 ^ (s4 & s0), mks_pkg::LANE_ROT3);
    s1 = mks_pkg::word_rotl(s1, 64);

    s4 = mks_pkg::lane_rotl(s4 ^ s2 ^ (s0 & s1), mks_pkg::LANE_ROT4);
    s2 = mks_pkg::word_rotl(s2, 32);

    state_o[0] = s0;
    state_o[1] = s1;
    state_o[2] = s2;
    state_o[3] = s3;
    state_o[4] = s4;
  end

endmodule

`default_nettype wire

// ===== rtl/core/morus640_zero_message_keystream.sv =====
// morus-640 zero-message keystream generator: an accepted step word's keystream
// word is on the output register in the next cycle; one word per cycle while
// the output does not stall, set by the combinational update of the state registers
// reset clears the 640-bit state to zero and empties the output register
// depends on mks_pkg, mks_if and mks_state_update
`default_nettype none

module morus640_zero_message_keystream (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mks_in_if.sink     in_i,
  mks_out_if.source  out_o
);

  mks_pkg::state_t state_q, state_d, state_next;
  mks_pkg::word_t  keystream;
  mks_pkg::word_t  ks_q, ks_d;
  logic            out_valid_q, out_valid_d;
  logic            in_fire, is_step;

  mks_state_update u_update (
    .state_i     (state_q),
    .keystream_o (keystream),
    .state_o     (state_next)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_step    = (in_i.action == mks_pkg::ACT_STEP);

  always_comb begin
    state_d = state_q;
    if (in_fire) begin
      if (is_step) begin
        state_d = state_next;
      end else begin
        for (int w = 0; w < mks_pkg::NUM_WORDS; w++) begin
          if (in_i.word_index == mks_pkg::IDX_W'(2 * w)) begin
            state_d[w][mks_pkg::HALF_W-1:0] = in_i.load_data;
          end
          if (in_i.word_index == mks_pkg::IDX_W'(2 * w + 1)) begin
            state_d[w][mks_pkg::WORD_W-1:mks_pkg::HALF_W] = in_i.load_data;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    ks_d        = ks_q;
    if (in_fire && is_step) begin
      out_valid_d = 1'b1;
      ks_d        = keystream;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < mks_pkg::NUM_WORDS; w++) begin
        state_q[w] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ks_q <= ks_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.keystream_low  = ks_q[mks_pkg::HALF_W-1:0];
  assign out_o.keystream_high = ks_q[mks_pkg::WORD_W-1:mks_pkg::HALF_W];

endmodule

`default_nettype wire

// ===== rtl/core/mks_checker.sv =====
// port-level checks for the keystream block, bound to its top level
// depends on mks_pkg and morus640_zero_message_keystream_assert.svh
`default_nettype none

`include "morus640_zero_message_keystream_assert.svh"

module mks_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_i,
  input wire logic                       in_action_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [mks_pkg::HALF_W-1:0] ks_low_i,
  input wire logic [mks_pkg::HALF_W-1:0] ks_high_i
);

  logic in_fire;
  logic out_stall;

  assign in_fire   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // a step word always produces a keystream word in the next cycle
  `MKS_ASSERT_NEXT(a_step_gives_word, clk_i, rst_ni,
                   in_fire && (in_action_i == mks_pkg::ACT_STEP), out_valid_i)

  // a load word never produces a keystream word
  `MKS_ASSERT_NEXT(a_load_gives_none, clk_i, rst_ni,
                   in_fire && (in_action_i == mks_pkg::ACT_LOAD), !out_valid_i)

  // an empty output register never holds back the input
  `MKS_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // a stalled keystream word holds
  `MKS_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_stall,
                   out_valid_i && $stable(ks_low_i) && $stable(ks_high_i))

endmodule

bind morus640_zero_message_keystream mks_checker u_mks_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .ks_low_i    (out_o.keystream_low),
  .ks_high_i   (out_o.keystream_high)
);

`default_nettype wire
